>>> design/assert_macros.svh
// Assertion macros shared by the stripe centroid line tracker modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define STCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define STCL_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/stcl_pkg.sv
// Package for the stripe centroid line tracker: widths, register indexes,
// reset values and the structs passed between the modules. No dependencies.
package stcl_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned MaxStripes  = 64;

  localparam int unsigned RegW        = 11;  // width and height registers
  localparam int unsigned StripesRegW = 7;
  localparam int unsigned IdxW        = 2;
  localparam int unsigned PixW        = 8;
  localparam int unsigned ColW        = 10;
  localparam int unsigned RowW        = 10;
  localparam int unsigned SidxW       = 6;
  localparam int unsigned SumW        = 30;
  localparam int unsigned CntW        = 21;
  localparam int unsigned NumW        = 32;  // 2*sum + count
  localparam int unsigned QuoW        = 11;  // centroid quotient, clamped later
  localparam int unsigned StepW       = 4;   // counts up to QuoW and RegW steps
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned OutDataW    = 32;

  typedef enum logic [IdxW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_STRIPE_COUNT = 2'd2
  } reg_idx_e;

  localparam logic [RegW-1:0]        WidthRst   = 11'd640;
  localparam logic [RegW-1:0]        HeightRst  = 11'd480;
  localparam logic [StripesRegW-1:0] StripesRst = 7'd8;
  localparam logic [RegW-1:0]        StripeHRst = 11'(480 / 8);

  typedef struct packed {
    logic [RegW-1:0]        eff_w;
    logic [RegW-1:0]        eff_h;
    logic [StripesRegW-1:0] eff_s;
    logic [RegW-1:0]        stripe_h;
    logic                   busy;     // stripe height being recomputed
    logic                   restart;  // register written this cycle
  } stcl_cfg_t;

  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [CntW-1:0]  count;
    logic [RowW-1:0]  crow;
    logic [SidxW-1:0] sidx;
    logic             last;
  } stcl_job_t;

endpackage

>>> design/stcl_cfg.sv
// Configuration registers, clamping and a bit-serial divider for the
// stripe height. Depends on stcl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stcl_cfg import stcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]  cfg_data_i,
  output stcl_cfg_t        cfg_o
);

  logic [RegW-1:0]        width_q, height_q;
  logic [StripesRegW-1:0] scount_q;
  logic [RegW-1:0]        stripe_h_q;
  logic                   pend_q, run_q;
  logic [RegW-1:0]        rem_q, quo_q;
  logic [RegW+ColW-1:0]   dsh_q;
  logic [StepW-1:0]       step_q;

  logic                   hit;
  logic [RegW-1:0]        eff_w, eff_h;
  logic [StripesRegW-1:0] s_clamp, eff_s;
  logic                   ge;
  logic [RegW-1:0]        quo_next;

  assign cfg_ready_o = 1'b1;
  assign hit = cfg_valid_i && (reg_idx_e'(cfg_index_i) == REG_IMAGE_WIDTH ||
                               reg_idx_e'(cfg_index_i) == REG_IMAGE_HEIGHT ||
                               reg_idx_e'(cfg_index_i) == REG_STRIPE_COUNT);

  always_comb begin
    eff_w = width_q;
    if (width_q == '0) eff_w = RegW'(1);
    else if (width_q > RegW'(MaxWidth)) eff_w = RegW'(MaxWidth);
    eff_h = height_q;
    if (height_q == '0) eff_h = RegW'(1);
    else if (height_q > RegW'(MaxHeight)) eff_h = RegW'(MaxHeight);
    s_clamp = scount_q;
    if (scount_q == '0) s_clamp = StripesRegW'(1);
    else if (scount_q > StripesRegW'(MaxStripes)) s_clamp = StripesRegW'(MaxStripes);
    // The height is below the stripe count here, so it fits the narrower field.
    eff_s = ({4'b0, s_clamp} > eff_h) ? eff_h[StripesRegW-1:0] : s_clamp;
  end

  assign ge       = {{ColW{1'b0}}, rem_q} >= dsh_q;
  assign quo_next = {quo_q[RegW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthRst;
      height_q   <= HeightRst;
      scount_q   <= StripesRst;
      stripe_h_q <= StripeHRst;
      pend_q     <= 1'b0;
      run_q      <= 1'b0;
      rem_q      <= '0;
      quo_q      <= '0;
      dsh_q      <= '0;
      step_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          REG_STRIPE_COUNT: scount_q <= cfg_data_i[StripesRegW-1:0];
          default: ;
        endcase
      end
      if (hit) begin
        pend_q <= 1'b1;
        run_q  <= 1'b0;
      end else if (pend_q) begin
        // Registers have settled, so the clamped values are current.
        pend_q <= 1'b0;
        run_q  <= 1'b1;
        rem_q  <= eff_h;
        dsh_q  <= {4'b0, eff_s, {ColW{1'b0}}};
        quo_q  <= '0;
        step_q <= StepW'(RegW);
      end else if (run_q) begin
        if (ge) rem_q <= rem_q - dsh_q[RegW-1:0];
        quo_q  <= quo_next;
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          run_q      <= 1'b0;
          stripe_h_q <= (quo_next == '0) ? RegW'(1) : quo_next;
        end
      end
    end
  end

  always_comb begin
    cfg_o.eff_w    = eff_w;
    cfg_o.eff_h    = eff_h;
    cfg_o.eff_s    = eff_s;
    cfg_o.stripe_h = stripe_h_q;
    cfg_o.busy     = pend_q | run_q;
    cfg_o.restart  = hit;
  end

  `STCL_ASSERT(a_stripe_h_nonzero, stripe_h_q != '0, "stripe height is zero")

endmodule

>>> design/stcl_front.sv
// Front end: takes pixels, tracks column, row and stripe, accumulates
// count and column sum, and queues one job per stripe. Depends on stcl_pkg.
`include "assert_macros.svh"

module stcl_front import stcl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stcl_cfg_t       cfg_i,
  input  logic            pix_valid_i,
  output logic            pix_ready_o,
  input  logic [PixW-1:0] pix_i,
  input  logic            full_i,
  output logic            push_o,
  output stcl_job_t       job_o
);

  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q, start_q;
  logic [SidxW-1:0] sidx_q;
  logic [SumW-1:0]  sum_q, sum_n;
  logic [CntW-1:0]  cnt_q, cnt_n;

  logic             accept, row_end, last_row, more_stripes, stripe_end;
  logic [RegW-1:0]  col_p1, end_row, rows_in;

  // Every transfer may close a stripe, so a free queue slot is required.
  // A register write restarts the frame, so no pixel is taken in that cycle.
  assign pix_ready_o = !cfg_i.busy && !cfg_i.restart && !full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    sum_n = sum_q;
    cnt_n = cnt_q;
    if (pix_i != '0) begin
      sum_n = sum_q + SumW'(col_q);
      cnt_n = cnt_q + CntW'(1);
    end
    col_p1       = {1'b0, col_q} + RegW'(1);
    row_end      = col_p1 >= cfg_i.eff_w;
    end_row      = {1'b0, row_q} + RegW'(1);
    last_row     = end_row >= cfg_i.eff_h;
    rows_in      = end_row - {1'b0, start_q};
    more_stripes = ({1'b0, sidx_q} + StripesRegW'(1)) < cfg_i.eff_s;
    stripe_end   = row_end && (last_row || (more_stripes && rows_in >= cfg_i.stripe_h));
  end

  assign push_o     = accept && stripe_end;
  assign job_o.sum  = sum_n;
  assign job_o.count = cnt_n;
  assign job_o.crow = start_q + rows_in[RowW:1];
  assign job_o.sidx = sidx_q;
  assign job_o.last = last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      start_q <= '0;
      sidx_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else if (cfg_i.restart) begin
      col_q   <= '0;
      row_q   <= '0;
      start_q <= '0;
      sidx_q  <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      col_q <= row_end ? '0 : col_p1[ColW-1:0];
      if (stripe_end) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_n;
        cnt_q <= cnt_n;
      end
      if (row_end) begin
        if (stripe_end && last_row) begin
          row_q   <= '0;
          start_q <= '0;
          sidx_q  <= '0;
        end else begin
          row_q <= end_row[RowW-1:0];
          if (stripe_end) begin
            start_q <= end_row[RowW-1:0];
            sidx_q  <= sidx_q + SidxW'(1);
          end
        end
      end
    end
  end

  `STCL_ASSERT(a_sidx_in_range, {1'b0, sidx_q} < cfg_i.eff_s, "stripe index past count")

endmodule

>>> design/stcl_queue.sv
// Short register queue of stripe jobs between the front and back ends.
// Depends on stcl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stcl_queue import stcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  stcl_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output stcl_job_t job_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FillW = $clog2(FifoDepth + 1);

  stcl_job_t        mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q;

  assign full_o  = fill_q == FillW'(FifoDepth);
  assign empty_o = fill_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i)      fill_q <= fill_q + FillW'(1);
      else if (pop_i && !push_i) fill_q <= fill_q - FillW'(1);
    end
  end

  `STCL_ASSERT(a_no_overflow, push_i |-> !full_o, "job pushed into full queue")
  `STCL_ASSERT(a_no_underflow, pop_i |-> !empty_o, "job popped from empty queue")

endmodule

>>> design/stcl_back.sv
// Back end: divides each stripe's column sum by its count one quotient bit
// per cycle, tracks the previous centre and holds the output register.
// Depends on stcl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stcl_back import stcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stcl_cfg_t        cfg_i,
  input  logic             empty_i,
  input  stcl_job_t        job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ColW-1:0]  out_col_o,
  output logic [RowW-1:0]  out_row_o,
  output logic [SidxW-1:0] out_sidx_o,
  output logic             out_seen_o,
  output logic             out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } back_state_e;

  back_state_e      state_q, state_d;
  logic [NumW-1:0]  rem_q, dsh_q;
  logic [QuoW-1:0]  quo_q;
  logic [StepW-1:0] step_q;
  logic [RowW-1:0]  crow_q;
  logic [SidxW-1:0] sidx_q;
  logic             last_q, seen_q;
  logic [ColW-1:0]  prev_q;
  logic             prev_init_q;

  logic             out_valid_q, out_seen_q, out_last_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic [SidxW-1:0] out_sidx_q;

  logic [ColW-1:0]  w_max, prev_eff, col_sel;
  logic             ge, out_free;

  assign w_max    = cfg_i.eff_w[ColW-1:0] - ColW'(1);
  // A fresh frame starts from the middle of the current width.
  assign prev_eff = prev_init_q ? cfg_i.eff_w[ColW:1] : prev_q;
  assign ge       = rem_q >= dsh_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    if (seen_q) col_sel = (quo_q > {1'b0, w_max}) ? w_max : quo_q[ColW-1:0];
    else        col_sel = (prev_eff > w_max) ? w_max : prev_eff;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!empty_i) state_d = (job_i.count == '0) ? S_OUT : S_DIV;
      S_DIV:  if (step_q == StepW'(1)) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_i.restart) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      prev_init_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.restart) begin
        prev_init_q <= 1'b1;
      end else if (state_q == S_OUT && out_free) begin
        prev_q      <= col_sel;
        prev_init_q <= last_q;
      end
      if (state_q == S_OUT && out_free && !cfg_i.restart) out_valid_q <= 1'b1;
      else if (out_ready_i)                                out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      crow_q <= job_i.crow;
      sidx_q <= job_i.sidx;
      last_q <= job_i.last;
      seen_q <= job_i.count != '0;
      rem_q  <= {job_i.sum, 1'b0} + NumW'(job_i.count);
      dsh_q  <= {job_i.count, 1'b0, {(QuoW-1){1'b0}}};
      quo_q  <= '0;
      step_q <= StepW'(QuoW);
    end else if (state_q == S_DIV) begin
      if (ge) rem_q <= rem_q - dsh_q;
      quo_q  <= {quo_q[QuoW-2:0], ge};
      dsh_q  <= dsh_q >> 1;
      step_q <= step_q - StepW'(1);
    end
    if (state_q == S_OUT && out_free) begin
      out_col_q  <= col_sel;
      out_row_q  <= crow_q;
      out_sidx_q <= sidx_q;
      out_seen_q <= seen_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign out_sidx_o  = out_sidx_q;
  assign out_seen_o  = out_seen_q;
  assign out_last_o  = out_last_q;

  `STCL_ASSERT(a_div_ends, (state_q == S_DIV && step_q == StepW'(1) && !cfg_i.restart) |=> state_q == S_OUT, "divider did not finish")

endmodule

>>> design/stripe_centroid_line_tracker_unit.sv
// Top level of the stripe centroid line tracker: configuration, pixel front
// end, job queue and centroid back end. Depends on stcl_pkg and all stcl_* modules.
//
//   channel  direction  transfer moves
//   s_axis   in         one pixel of the binary image, raster order
//   m_axis   out        one stripe result: centre column, row, stripe index
//   cfg      in         one register write (width, height, stripe count)
//
// Pixels are taken one per cycle while the two-entry job queue has room and
// the configuration is settled. A stripe with line pixels passes through the
// back end's idle, bit-serial centroid divider and output states, an empty
// one skips the divider; short stripes back up the queue and stall the pixel
// side. After reset the block runs at once; a register write takes no pixel
// in its own cycle nor after it while the stripe height is worked out. A
// stalled result waits in the output register.
module stripe_centroid_line_tracker_unit import stcl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [PixW-1:0]     s_axis_tdata_i,   // [7:0] pixel_value
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [9:0] center_col, [19:10] center_row,
                                                // [25:20] stripe_number, rest zero
  output logic [0:0]          m_axis_tuser_o,   // [0] line_seen
  output logic                m_axis_tlast_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IdxW-1:0]     cfg_index_i,
  input  logic [RegW-1:0]     cfg_data_i
);

  stcl_cfg_t        cfg;
  stcl_job_t        push_job, pop_job;
  logic             push, pop, full, empty;
  logic [ColW-1:0]  out_col;
  logic [RowW-1:0]  out_row;
  logic [SidxW-1:0] out_sidx;
  logic             out_seen;

  stcl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  stcl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pix_valid_i (s_axis_tvalid_i),
    .pix_ready_o (s_axis_tready_o),
    .pix_i       (s_axis_tdata_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  stcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (pop_job)
  );

  stcl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_col_o   (out_col),
    .out_row_o   (out_row),
    .out_sidx_o  (out_sidx),
    .out_seen_o  (out_seen),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataW - ColW - RowW - SidxW){1'b0}}, out_sidx, out_row, out_col};
  assign m_axis_tuser_o = out_seen;

endmodule
